// File: sv/frequency_sorted_symbol_table_unit_defines.svh
// Assertion macros shared by the checker
`ifndef FREQUENCY_SORTED_SYMBOL_TABLE_UNIT_DEFINES_SVH
`define FREQUENCY_SORTED_SYMBOL_TABLE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define FST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/fst_pkg.sv
package fst_pkg;

    localparam int Capacity  = 256;
    localparam int KeyBits   = 16;
    localparam int CountBits = 32;
    localparam int IdxBits   = $clog2(Capacity);
    localparam int LenBits   = $clog2(Capacity + 1);

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_RANK  = 2'd1;
    localparam logic [1:0] ACT_ENTRY = 2'd2;
    localparam logic [1:0] ACT_PRUNE = 2'd3;

    typedef logic [KeyBits-1:0]   t_key;
    typedef logic [CountBits-1:0] t_count;
    typedef logic [IdxBits-1:0]   t_idx;
    typedef logic [LenBits-1:0]   t_len;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // register the accepted item
        logic lookup;   // search cells and register findings
        logic update;   // apply increment, move, append or prune
        logic respond;  // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

// File: sv/fst_ctrl.sv
module fst_ctrl
    import fst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_ready = (r_state == ST_IDLE);

    // Step through lookup, update and response
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!i_status.out_busy) begin
                    o_cmd.respond = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/fst_datapath.sv
module fst_datapath
    import fst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [1:0] i_action,
    input  t_key       i_key,
    input  logic [7:0] i_rank,
    input  t_count     i_threshold,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_found,
    output logic [7:0] o_position,
    output t_key       o_entry_key,
    output t_count     o_entry_count,
    output t_len       o_table_length,
    output logic       o_table_full
);

    // Row of cells, each holding one entry
    t_key   r_keys   [Capacity];
    t_count r_counts [Capacity];
    t_len   r_len;

    logic [1:0] r_act;
    t_key       r_key;
    logic [7:0] r_rank;
    t_count     r_thr;

    // Findings of the lookup step
    logic   r_hit;
    t_idx   r_hit_idx;
    t_count r_cnt_at;
    t_count r_new_cnt;
    t_idx   r_dest;
    t_len   r_cut;

    logic   r_res_found;
    t_idx   r_res_pos;
    t_key   r_res_key;
    t_count r_res_cnt;
    logic   r_res_full;

    logic   r_ovalid;
    logic   r_o_found;
    logic [7:0] r_o_pos;
    t_key   r_o_key;
    t_count r_o_cnt;
    t_len   r_o_len;
    logic   r_o_full;

    logic [Capacity-1:0] w_match, w_live, w_below, w_lt_new;
    logic   w_hit;
    t_idx   w_hit_idx;
    t_count w_cnt_at;
    logic   w_sat;
    t_count w_inc;
    t_idx   w_dest;
    t_len   w_cut;

    // Compare in every cell at once
    always_comb begin
        for (int i = 0; i < Capacity; i++) begin
            w_live[i]  = (LenBits'(i) < r_len);
            w_match[i] = w_live[i] && (r_keys[i] == r_key);
            w_below[i] = w_live[i] && (r_counts[i] < r_thr);
        end
    end

    // Priority encode first match and first pruned cell
    always_comb begin
        w_hit = 1'b0;
        w_hit_idx = '0;
        w_cut = r_len;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit = 1'b1;
                w_hit_idx = IdxBits'(i);
            end
            if (w_below[i]) w_cut = LenBits'(i);
        end
    end

    // Gather the count of the matching cell (keys are unique, so at most one)
    always_comb begin
        w_cnt_at = '0;
        for (int i = 0; i < Capacity; i++)
            w_cnt_at = w_cnt_at | (r_counts[i] & {CountBits{w_match[i]}});
    end

    assign w_sat = (w_cnt_at == '1);
    assign w_inc = w_sat ? w_cnt_at : w_cnt_at + 1'b1;

    // Destination: first cell whose count is below the new one
    always_comb begin
        for (int i = 0; i < Capacity; i++)
            w_lt_new[i] = w_sat ? (r_counts[i] < w_cnt_at) : (r_counts[i] <= w_cnt_at);
        w_dest = w_hit_idx;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (w_lt_new[i] && (IdxBits'(i) < w_hit_idx)) w_dest = IdxBits'(i);
        end
    end

    // Capture the item and the lookup findings
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_key  <= i_key;
            r_rank <= i_rank;
            r_thr  <= i_threshold;
        end
        if (i_cmd.lookup) begin
            r_hit     <= w_hit;
            r_hit_idx <= w_hit_idx;
            r_cnt_at  <= w_cnt_at;
            r_new_cnt <= w_inc;
            r_dest    <= w_dest;
            r_cut     <= w_cut;
        end
    end

    // Apply the operation to the cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            case (r_act)
                ACT_ADD: begin
                    if (r_hit) begin
                        for (int i = 1; i < Capacity; i++) begin
                            if ((IdxBits'(i) > r_dest) && (IdxBits'(i) <= r_hit_idx)) begin
                                r_keys[i]   <= r_keys[i-1];
                                r_counts[i] <= r_counts[i-1];
                            end
                        end
                        r_keys[r_dest]   <= r_key;
                        r_counts[r_dest] <= r_new_cnt;
                    end else if (r_len != LenBits'(Capacity)) begin
                        r_keys[r_len[IdxBits-1:0]]   <= r_key;
                        r_counts[r_len[IdxBits-1:0]] <= CountBits'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Length and result of the operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.update) begin
            r_res_full  <= 1'b0;
            r_res_found <= 1'b0;
            r_res_pos   <= '0;
            r_res_key   <= '0;
            r_res_cnt   <= '0;
            case (r_act)
                ACT_ADD: begin
                    r_res_key <= r_key;
                    if (r_hit) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= r_dest;
                        r_res_cnt   <= r_new_cnt;
                    end else if (r_len != LenBits'(Capacity)) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= r_len[IdxBits-1:0];
                        r_res_cnt   <= CountBits'(1);
                        r_len       <= r_len + 1'b1;
                    end else begin
                        r_res_full <= 1'b1;
                    end
                end
                ACT_RANK: begin
                    r_res_key <= r_key;
                    if (r_hit) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= r_hit_idx;
                        r_res_cnt   <= r_cnt_at;
                    end
                end
                ACT_ENTRY: begin
                    if (LenBits'(r_rank) < r_len) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= IdxBits'(r_rank);
                        r_res_key   <= r_keys[IdxBits'(r_rank)];
                        r_res_cnt   <= r_counts[IdxBits'(r_rank)];
                    end
                end
                ACT_PRUNE: begin
                    if (r_thr > CountBits'(1)) r_len <= r_cut;
                end
                default: ;
            endcase
        end
    end

    // Output register, held until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.respond) begin
            r_ovalid  <= 1'b1;
            r_o_found <= r_res_found;
            r_o_pos   <= 8'(r_res_pos);
            r_o_key   <= r_res_key;
            r_o_cnt   <= r_res_cnt;
            r_o_len   <= r_len;
            r_o_full  <= r_res_full;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_ovalid && !i_ready;
    assign o_valid        = r_ovalid;
    assign o_found        = r_o_found;
    assign o_position     = r_o_pos;
    assign o_entry_key    = r_o_key;
    assign o_entry_count  = r_o_cnt;
    assign o_table_length = r_o_len;
    assign o_table_full   = r_o_full;

endmodule

// File: sv/frequency_sorted_symbol_table_unit.sv
// Frequency-sorted table of up to 256 16-bit keys with saturating 32-bit counts,
// kept in descending count order (ties in arrival order). Each item passes through four
// steps: capture, parallel key match and move-target search across all cells, the
// update (a shift of the tied run with count update, an append or a prune), and the
// result load into the output register. One item is in flight at a time: the result
// waits in the last step until the output register is free or being emptied, and the
// next item is accepted in the cycle after the result is loaded.
module frequency_sorted_symbol_table_unit
    import fst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], key[17:2], rank[25:18], threshold[57:26], zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], position[8:1], entry_key[24:9], entry_count[56:25],
    // table_length[65:57], table_full[66], zero pad
    output logic [71:0] m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;
    logic       w_found, w_full;
    logic [7:0] w_pos;
    t_key       w_key;
    t_count     w_cnt;
    t_len       w_len;

    fst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fst_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_action       (s_axis_tdata[1:0]),
        .i_key          (s_axis_tdata[17:2]),
        .i_rank         (s_axis_tdata[25:18]),
        .i_threshold    (s_axis_tdata[57:26]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_found        (w_found),
        .o_position     (w_pos),
        .o_entry_key    (w_key),
        .o_entry_count  (w_cnt),
        .o_table_length (w_len),
        .o_table_full   (w_full)
    );

    assign m_axis_tdata = {5'd0, w_full, w_len, w_cnt, w_key, w_pos, w_found};

endmodule

// File: sv/fst_checker.sv
`include "frequency_sorted_symbol_table_unit_defines.svh"

module fst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // Result held while stalled
    `FST_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // No new item taken right after one was accepted
    `FST_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A refused key never reports found
    `FST_ASSERT_IMP(a_full_nf, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[66], !m_axis_tdata[0])
    // Length never exceeds capacity
    `FST_ASSERT_IMP(a_len, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[65:57] <= 9'd256)

endmodule

bind frequency_sorted_symbol_table_unit fst_checker u_fst_checker (.*);
